/* rtl/core/lrc_pkg.sv */
// ----------------------------------------------------------------------------
// lrc_pkg: shared constants and helpers for the line rectangle clipper
// fixed-point limits of the clip parameter and window inset
// ----------------------------------------------------------------------------
package lrc_pkg;

    // quotient bits produced by the divider chain (magnitude below 2.0 in Q.16)
    localparam int QW = 17;
    // signed width of a clip parameter t, holds [-2, 2] in Q.16
    localparam int TW = 19;

    localparam logic [14:0]          INSET_MAX = 15'd32112;
    localparam logic signed [TW-1:0] T_ONE     = 19'sd65536;
    localparam logic signed [TW-1:0] T_SAT     = 19'sd131072;
    localparam logic signed [TW-1:0] T_ZERO    = 19'sd0;

    // signed, saturated parameter from divider magnitude
    function automatic logic signed [TW-1:0] t_value(
        input logic [QW-1:0] mag,
        input logic          sat,
        input logic          neg
    );
        logic signed [TW-1:0] m;
        m = sat ? T_SAT : $signed({{(TW-QW){1'b0}}, mag});
        return neg ? -m : m;
    endfunction

endpackage

/* rtl/core/line_rect_clip_core.sv */
// ----------------------------------------------------------------------------
// line_rect_clip_core: Liang-Barsky clipping of a 2D segment to a square window
// pipelined divider chain, interval combine, lerp multiply and output register
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | i_valid / o_ready, i_start_*, i_end_* | in
//  output   | o_valid / i_ready, o_visible, o_clip_* | out
//  config   | i_cfg_we, i_cfg_data (window inset)    | in
//
//  one word per clock while the output register is empty or taken; stages in order
//  (prep, QW divider cells, combine, multiply, output register)
//  the whole pipe advances when the output register is empty or taken
//  synchronous active-low reset clears valid bits and sets inset to 0
// ----------------------------------------------------------------------------
module line_rect_clip_core #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [14:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_visible,
    output logic signed [COORD_WIDTH-1:0] o_clip_start_x,
    output logic signed [COORD_WIDTH-1:0] o_clip_start_y,
    output logic signed [COORD_WIDTH-1:0] o_clip_end_x,
    output logic signed [COORD_WIDTH-1:0] o_clip_end_y
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = W + 1;                 // delta / numerator magnitude
    localparam int RW = W + 2;                 // signed numerator, remainder
    localparam int QW = lrc_pkg::QW;
    localparam int TW = lrc_pkg::TW;
    localparam int PW = NW + TW;               // lerp product
    localparam int NS = QW + 4;                // valid stages

    typedef struct packed {
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sy;
        logic signed [W-1:0] ex;
        logic signed [W-1:0] ey;
        logic [3:0]          neg;
        logic [3:0]          sat;
    } t_side;

    // ---------------- config register ----------------
    logic [14:0] r_inset;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inset <= '0;
        end else if (i_cfg_we) begin
            r_inset <= (i_cfg_data > lrc_pkg::INSET_MAX) ? lrc_pkg::INSET_MAX : i_cfg_data;
        end
    end

    logic signed [RW-1:0] lo_b, hi_b;
    assign lo_b = $signed({{(RW-15){1'b0}}, r_inset});
    assign hi_b = $signed(RW'(65536)) - lo_b;

    // ---------------- pipe control ----------------
    logic          en;
    logic [NS-1:0] r_vld;
    assign en      = !r_vld[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // ---------------- prep: numerators, deltas, sign and saturation ----------------
    logic signed [NW-1:0] dx, dy;
    logic signed [RW-1:0] num [4];
    logic signed [NW-1:0] dd  [4];
    logic [NW-1:0]        nmag[4];
    logic [NW-1:0]        dmag[4];
    logic [3:0]           p_neg, p_sat;

    assign dx = {i_end_x[W-1], i_end_x} - {i_start_x[W-1], i_start_x};
    assign dy = {i_end_y[W-1], i_end_y} - {i_start_y[W-1], i_start_y};

    always_comb begin
        num[0] = lo_b - RW'(i_start_x);
        num[1] = hi_b - RW'(i_start_x);
        num[2] = lo_b - RW'(i_start_y);
        num[3] = hi_b - RW'(i_start_y);
        dd[0] = dx;
        dd[1] = dx;
        dd[2] = dy;
        dd[3] = dy;
        for (int k = 0; k < 4; k++) begin
            nmag[k]  = num[k][RW-1] ? NW'(-num[k]) : NW'(num[k]);
            dmag[k]  = dd[k][NW-1] ? (-dd[k]) : dd[k];
            // quotient of two or more saturates
            p_sat[k] = {1'b0, nmag[k]} >= {dmag[k], 1'b0};
            p_neg[k] = num[k][RW-1] ^ dd[k][NW-1];
        end
    end

    logic [NW-1:0] r_p_num[4];
    logic [NW-1:0] r_p_den[4];
    t_side         r_p_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_p_num[k] <= nmag[k];
                r_p_den[k] <= dmag[k];
            end
            r_p_side <= '{sx: i_start_x, sy: i_start_y, ex: i_end_x, ey: i_end_y,
                          neg: p_neg, sat: p_sat};
        end
    end

    // ---------------- divider chain: one quotient bit per cell ----------------
    logic [RW-1:0] c_rem[QW+1][4];
    logic [NW-1:0] c_den[QW+1][4];
    logic [QW-1:0] c_quo[QW+1][4];
    t_side         sb   [QW+1];

    assign sb[0] = r_p_side;
    for (genvar l = 0; l < 4; l++) begin : g_seed
        assign c_rem[0][l] = {1'b0, r_p_num[l]};
        assign c_den[0][l] = r_p_den[l];
        assign c_quo[0][l] = '0;
    end

    for (genvar g = 0; g < QW; g++) begin : g_stage
        t_side r_sb;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sb <= sb[g];
            end
        end
        assign sb[g+1] = r_sb;

        for (genvar l = 0; l < 4; l++) begin : g_lane
            lrc_div_cell #(.W(W)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (c_rem[g][l]),
                .i_den (c_den[g][l]),
                .i_quo (c_quo[g][l]),
                .o_rem (c_rem[g+1][l]),
                .o_den (c_den[g+1][l]),
                .o_quo (c_quo[g+1][l])
            );
        end
    end

    // ---------------- combine: narrow the entry/exit interval ----------------
    t_side                side_q;
    logic signed [TW-1:0] tq[4];
    logic signed [TW-1:0] ax, bx, ay, by;
    logic signed [TW-1:0] tmin1, tmax1, tmin2, tmax2;
    logic signed [NW-1:0] cdx, cdy;
    logic                 pass_x, pass_y;

    assign side_q = sb[QW];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tq[k] = lrc_pkg::t_value(c_quo[QW][k], side_q.sat[k], side_q.neg[k]);
        end
        cdx = {side_q.ex[W-1], side_q.ex} - {side_q.sx[W-1], side_q.sx};
        cdy = {side_q.ey[W-1], side_q.ey} - {side_q.sy[W-1], side_q.sy};
        ax = (tq[0] > tq[1]) ? tq[1] : tq[0];
        bx = (tq[0] > tq[1]) ? tq[0] : tq[1];
        ay = (tq[2] > tq[3]) ? tq[3] : tq[2];
        by = (tq[2] > tq[3]) ? tq[2] : tq[3];

        // x axis, zero delta passes only with origin inside the window
        if (cdx == '0) begin
            tmin1  = lrc_pkg::T_ZERO;
            tmax1  = lrc_pkg::T_ONE;
            pass_x = (RW'(side_q.sx) >= lo_b) && (RW'(side_q.sx) <= hi_b);
        end else begin
            tmin1  = (ax > lrc_pkg::T_ZERO) ? ax : lrc_pkg::T_ZERO;
            tmax1  = (bx < lrc_pkg::T_ONE) ? bx : lrc_pkg::T_ONE;
            pass_x = tmin1 <= tmax1;
        end

        if (cdy == '0) begin
            tmin2  = tmin1;
            tmax2  = tmax1;
            pass_y = (RW'(side_q.sy) >= lo_b) && (RW'(side_q.sy) <= hi_b);
        end else begin
            tmin2  = (ay > tmin1) ? ay : tmin1;
            tmax2  = (by < tmax1) ? by : tmax1;
            pass_y = tmin2 <= tmax2;
        end
    end

    logic                 r_c_vis;
    logic signed [TW-1:0] r_c_tmin, r_c_tmax;
    logic signed [NW-1:0] r_c_dx, r_c_dy;
    t_side                r_c_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_vis  <= pass_x && pass_y;
            r_c_tmin <= tmin2;
            r_c_tmax <= tmax2;
            r_c_dx   <= cdx;
            r_c_dy   <= cdy;
            r_c_side <= side_q;
        end
    end

    // ---------------- multiply: delta times parameter ----------------
    logic signed [PW-1:0] r_m_p[4];
    logic                 r_m_vis;
    t_side                r_m_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_p[0] <= r_c_dx * r_c_tmin;
            r_m_p[1] <= r_c_dy * r_c_tmin;
            r_m_p[2] <= r_c_dx * r_c_tmax;
            r_m_p[3] <= r_c_dy * r_c_tmax;
            r_m_vis  <= r_c_vis;
            r_m_side <= r_c_side;
        end
    end

    // ---------------- round to nearest, add start, output register ----------------
    logic signed [PW-1:0] rnd[4];
    logic signed [W-1:0]  pt [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (r_m_p[k] + PW'(32768)) >>> 16;
        end
        pt[0] = r_m_side.sx + rnd[0][W-1:0];
        pt[1] = r_m_side.sy + rnd[1][W-1:0];
        pt[2] = r_m_side.sx + rnd[2][W-1:0];
        pt[3] = r_m_side.sy + rnd[3][W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_visible      <= r_m_vis;
            o_clip_start_x <= r_m_vis ? pt[0] : r_m_side.sx;
            o_clip_start_y <= r_m_vis ? pt[1] : r_m_side.sy;
            o_clip_end_x   <= r_m_vis ? pt[2] : r_m_side.ex;
            o_clip_end_y   <= r_m_vis ? pt[3] : r_m_side.ey;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output register state");

    a_inset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inset <= lrc_pkg::INSET_MAX)
        else $error("inset above clamp");

    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW+1] && r_c_vis |-> (r_c_tmin <= r_c_tmax) && (r_c_tmin >= lrc_pkg::T_ZERO)
            && (r_c_tmax <= lrc_pkg::T_ONE))
        else $error("visible word with bad interval");
`endif
endmodule

/* rtl/core/lrc_div_cell.sv */
// ----------------------------------------------------------------------------
// lrc_div_cell: one restoring-division step
// produces one quotient bit and hands remainder and divisor to the next cell
// ----------------------------------------------------------------------------
module lrc_div_cell #(
    parameter int W = 24
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [W+1:0]               i_rem,
    input  logic [W:0]                 i_den,
    input  logic [lrc_pkg::QW-1:0]     i_quo,
    output logic [W+1:0]               o_rem,
    output logic [W:0]                 o_den,
    output logic [lrc_pkg::QW-1:0]     o_quo
);
    localparam int RW = W + 2;

    logic          ge;
    logic [RW-1:0] diff;
    logic [RW-1:0] r_rem;
    logic [W:0]    r_den;
    logic [lrc_pkg::QW-1:0] r_quo;

    assign ge   = i_rem >= {1'b0, i_den};
    assign diff = ge ? (i_rem - {1'b0, i_den}) : i_rem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= {diff[RW-2:0], 1'b0};
            r_den <= i_den;
            r_quo <= {i_quo[lrc_pkg::QW-2:0], ge};
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
endmodule
